[rtl/opf_pkg.sv]
// Shared types, constants and CRC function for the Ogg page framer.
package opf_pkg;

    localparam logic [31:0] CRC_POLY     = 32'h04C1_1DB7;
    localparam logic [31:0] SERIAL_RESET = 32'h5341_4D41;
    localparam logic [12:0] MAX_PAYLOAD  = 13'd4095;
    localparam logic [4:0]  NSEG_MAX     = 5'd17;
    localparam logic [4:0]  HDR_LAST     = 5'd26;
    localparam logic [7:0]  LACE_MAX     = 8'd255;

    localparam logic        OP_START     = 1'b0;
    localparam logic        OP_BYTE      = 1'b1;

    localparam logic [7:0]  CAP_O        = 8'h4F;
    localparam logic [7:0]  CAP_G        = 8'h67;
    localparam logic [7:0]  CAP_S        = 8'h53;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HEADER,
        ST_LACE,
        ST_PAYLOAD
    } t_opf_state;

    typedef struct packed {
        logic start_load;
        logic emit_hdr;
        logic emit_lace;
        logic emit_pay;
    } t_opf_cmd;

    typedef struct packed {
        logic can_load;
        logic reject;
        logic hdr_done;
        logic lace_last;
        logic len_zero;
        logic pay_last;
    } t_opf_sts;

    // MSB-first CRC, one byte per call
    function automatic logic [31:0] crc_add(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {b, 24'h0};
        for (int i = 0; i < 8; i++) begin
            r = r[31] ? ({r[30:0], 1'b0} ^ CRC_POLY) : {r[30:0], 1'b0};
        end
        return r;
    endfunction

endpackage

[rtl/opf_ctrl.sv]
// Control state machine for the Ogg page framer.
module opf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    input  logic              i_op,
    output logic              o_s_tready,
    input  opf_pkg::t_opf_sts i_sts,
    output opf_pkg::t_opf_cmd o_cmd
);
    import opf_pkg::*;

    t_opf_state r_state;
    t_opf_state n_state;
    logic       w_accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign w_accept = i_s_tvalid && i_sts.can_load;

    always_comb begin
        n_state    = r_state;
        o_s_tready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            ST_IDLE, ST_PAYLOAD: begin
                o_s_tready = i_sts.can_load;
                if (w_accept) begin
                    if (i_op == OP_START) begin
                        o_cmd.start_load = 1'b1;
                        n_state = i_sts.reject ? ST_IDLE : ST_HEADER;
                    end else if (r_state == ST_PAYLOAD) begin
                        o_cmd.emit_pay = 1'b1;
                        if (i_sts.pay_last) begin
                            n_state = ST_IDLE;
                        end
                    end
                end
            end
            ST_HEADER: begin
                if (i_sts.can_load) begin
                    o_cmd.emit_hdr = 1'b1;
                    if (i_sts.hdr_done) begin
                        n_state = ST_LACE;
                    end
                end
            end
            ST_LACE: begin
                if (i_sts.can_load) begin
                    o_cmd.emit_lace = 1'b1;
                    if (i_sts.lace_last) begin
                        n_state = i_sts.len_zero ? ST_IDLE : ST_PAYLOAD;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.start_load, o_cmd.emit_hdr, o_cmd.emit_lace, o_cmd.emit_pay}))
        else $error("more than one command at once");

    a_emit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit_hdr || o_cmd.emit_lace || o_cmd.emit_pay) |-> i_sts.can_load)
        else $error("byte emitted with output register full");

    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_HEADER || r_state == ST_LACE) |-> !o_s_tready)
        else $error("input taken while header is going out");

endmodule

[rtl/opf_dp.sv]
// Datapath for the Ogg page framer: header fields, lacing, CRC and output register.
module opf_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [31:0]       i_cfg_wdata,
    input  logic [119:0]      i_s_tdata,
    input  opf_pkg::t_opf_cmd i_cmd,
    output opf_pkg::t_opf_sts o_sts,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [39:0]       o_m_tdata,
    output logic              o_m_tlast
);
    import opf_pkg::*;

    logic [2:0]  w_flags;
    logic [63:0] w_gran;
    logic [31:0] w_seq;
    logic [11:0] w_len;
    logic [7:0]  w_pbyte;
    logic [12:0] w_qsum;
    logic [4:0]  w_nseg;

    logic [31:0] r_serial;
    logic [2:0]  r_flags;
    logic [63:0] r_gran;
    logic [31:0] r_seq;
    logic [4:0]  r_nseg;
    logic        r_len_zero;
    logic [11:0] r_lace;
    logic [11:0] r_left;
    logic [4:0]  r_idx;
    logic [31:0] r_crc;

    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic        r_out_last;
    logic [31:0] r_out_crc;

    logic [7:0]  w_hdr_byte;
    logic [7:0]  w_lace_byte;
    logic [7:0]  w_byte;
    logic        w_last;
    logic        w_emit;
    logic [31:0] w_crc_next;
    logic [2:0]  w_gsel;
    logic [1:0]  w_wsel;

    assign w_flags = i_s_tdata[2:0];
    assign w_gran  = i_s_tdata[66:3];
    assign w_seq   = i_s_tdata[98:67];
    assign w_len   = i_s_tdata[110:99];
    assign w_pbyte = i_s_tdata[118:111];

    // len / 255, exact below 65535
    assign w_qsum = {1'b0, w_len} + 13'd1 + {5'd0, w_len[11:8]};
    assign w_nseg = w_qsum[12:8] + 5'd1;

    assign o_sts.can_load  = !r_out_valid || i_m_tready;
    assign o_sts.reject    = ({1'b0, w_len} > MAX_PAYLOAD) || (w_nseg > NSEG_MAX);
    assign o_sts.hdr_done  = (r_idx == HDR_LAST);
    assign o_sts.lace_last = (r_lace < {4'd0, LACE_MAX});
    assign o_sts.len_zero  = r_len_zero;
    assign o_sts.pay_last  = (r_left == 12'd1);

    assign w_gsel = r_idx[2:0] - 3'd6;
    assign w_wsel = r_idx[1:0] - 2'd2;

    always_comb begin
        if (r_idx == 5'd0) begin
            w_hdr_byte = CAP_O;
        end else if (r_idx == 5'd1 || r_idx == 5'd2) begin
            w_hdr_byte = CAP_G;
        end else if (r_idx == 5'd3) begin
            w_hdr_byte = CAP_S;
        end else if (r_idx == 5'd5) begin
            w_hdr_byte = {5'd0, r_flags};
        end else if (r_idx >= 5'd6 && r_idx <= 5'd13) begin
            w_hdr_byte = r_gran[{w_gsel, 3'b000} +: 8];
        end else if (r_idx >= 5'd14 && r_idx <= 5'd17) begin
            w_hdr_byte = r_serial[{w_wsel, 3'b000} +: 8];
        end else if (r_idx >= 5'd18 && r_idx <= 5'd21) begin
            w_hdr_byte = r_seq[{w_wsel, 3'b000} +: 8];
        end else if (r_idx == HDR_LAST) begin
            w_hdr_byte = {3'd0, r_nseg};
        end else begin
            w_hdr_byte = 8'd0;
        end
    end

    assign w_lace_byte = o_sts.lace_last ? r_lace[7:0] : LACE_MAX;

    always_comb begin
        w_byte = w_hdr_byte;
        w_last = 1'b0;
        if (i_cmd.emit_lace) begin
            w_byte = w_lace_byte;
            w_last = r_len_zero && o_sts.lace_last;
        end else if (i_cmd.emit_pay) begin
            w_byte = w_pbyte;
            w_last = o_sts.pay_last;
        end
    end

    assign w_emit     = i_cmd.emit_hdr || i_cmd.emit_lace || i_cmd.emit_pay;
    assign w_crc_next = crc_add(r_crc, w_byte);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_serial    <= SERIAL_RESET;
            r_crc       <= '0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_serial <= i_cfg_wdata;
            end
            if (i_cmd.start_load) begin
                r_crc  <= '0;
                r_left <= w_len;
            end else if (w_emit) begin
                r_crc <= w_last ? 32'd0 : w_crc_next;
                if (i_cmd.emit_pay) begin
                    r_left <= r_left - 12'd1;
                end
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_load) begin
            r_flags    <= w_flags;
            r_gran     <= w_gran;
            r_seq      <= w_seq;
            r_nseg     <= w_nseg;
            r_len_zero <= (w_len == 12'd0);
            r_lace     <= w_len;
            r_idx      <= '0;
        end else if (i_cmd.emit_hdr) begin
            r_idx <= r_idx + 5'd1;
        end else if (i_cmd.emit_lace && !o_sts.lace_last) begin
            r_lace <= r_lace - {4'd0, LACE_MAX};
        end
        if (w_emit) begin
            r_out_byte <= w_byte;
            r_out_last <= w_last;
            r_out_crc  <= w_last ? w_crc_next : 32'd0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_crc, r_out_byte};
    assign o_m_tlast  = r_out_last;

    a_crc_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tlast) |-> (o_m_tdata[39:8] == 32'd0))
        else $error("CRC field set on a byte that is not last");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_hdr |-> (r_idx <= HDR_LAST))
        else $error("header index out of range");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && w_last) |=> (r_crc == 32'd0))
        else $error("CRC not cleared after end of page");

endmodule

[rtl/ogg_page_framer_crc32.sv]
// Ogg page framer: a page per unrejected start item, page CRC sent with the last byte.
// Start item: first byte out via the state and output registers, then 28 to 44 bytes
//   (27 header, 1 to 17 lacing) at one byte per cycle unless stalled; no input meanwhile.
// Payload byte: through the single output register, one byte per cycle unless stalled.
// The CRC advances one byte per cycle unless output stalls, through a byte-wide update.
// Synchronous active-low reset: no page open, CRC zero, serial 0x53414D41.
module ogg_page_framer_crc32 (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [31:0]  i_cfg_wdata,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // [2:0] header_flags, [66:3] granule_position, [98:67] page_sequence,
    // [110:99] payload_length, [118:111] payload_byte, [119] zero
    input  logic [119:0] i_s_tdata,
    // [0] operation
    input  logic         i_s_tuser,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // [7:0] page_byte, [39:8] page_crc
    output logic [39:0]  o_m_tdata,
    output logic         o_m_tlast
);
    import opf_pkg::*;

    t_opf_cmd w_cmd;
    t_opf_sts w_sts;

    opf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_op       (i_s_tuser),
        .o_s_tready (o_s_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    opf_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tdata   (i_s_tdata),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast)
    );

endmodule

[tb/sv/ogg_page_checker.sv]
`timescale 1ns / 100ps
// Scoreboard for the Ogg page framer: predicts every page byte, last flag and CRC and compares.
module ogg_page_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [31:0]  i_cfg_wdata,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    input  logic [119:0] i_s_tdata,
    input  logic         i_s_tuser,
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    input  logic [39:0]  i_m_tdata,
    input  logic         i_m_tlast,
    output int           o_errors,
    output int           o_pending,
    output int           o_pages,
    output int           o_bytes
);
    import opf_pkg::*;

    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        logic [31:0] crc;
    } t_page_word;

    t_page_word  expected_words[$];
    logic [31:0] serial;
    logic [31:0] page_crc_acc;
    logic [11:0] left_count;
    logic        open_page;
    int          err_count  = 0;
    int          page_count = 0;
    int          byte_count = 0;

    // bit-serial form, data MSB first
    function automatic logic [31:0] crc_next(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        logic        fb;
        r = c;
        for (int i = 7; i >= 0; i--) begin
            fb = r[31] ^ b[i];
            r  = {r[30:0], 1'b0} ^ (fb ? CRC_POLY : 32'h0);
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        err_count++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic emit_byte(input logic [7:0] b, input logic last);
        t_page_word word;
        page_crc_acc = crc_next(page_crc_acc, b);
        word = '{data: b, last: last, crc: last ? page_crc_acc : 32'h0};
        expected_words = {expected_words, word};
    endtask

    task automatic predict_start(input logic [119:0] d);
        logic [11:0] len;
        logic [63:0] gran;
        logic [31:0] seq;
        logic [7:0]  hdr[0:43];
        int          nseg;
        int          total;
        len  = d[110:99];
        gran = d[66:3];
        seq  = d[98:67];
        page_crc_acc = 32'h0;
        open_page    = 1'b0;
        left_count   = 12'h0;
        nseg = len / LACE_MAX + 1;
        if (len > MAX_PAYLOAD || nseg > NSEG_MAX) return;
        hdr[0] = CAP_O;
        hdr[1] = CAP_G;
        hdr[2] = CAP_G;
        hdr[3] = CAP_S;
        hdr[4] = 8'h00;
        hdr[5] = {5'b0, d[2:0]};
        for (int i = 0; i < 8; i++) hdr[6 + i] = gran[8 * i +: 8];
        for (int i = 0; i < 4; i++) begin
            hdr[14 + i] = serial[8 * i +: 8];
            hdr[18 + i] = seq[8 * i +: 8];
            hdr[22 + i] = 8'h00;
        end
        hdr[26] = nseg[7:0];
        for (int i = 0; i < nseg - 1; i++) hdr[27 + i] = LACE_MAX;
        hdr[26 + nseg] = 8'(len % LACE_MAX);
        total = 27 + nseg;
        for (int k = 0; k < total; k++) begin
            emit_byte(hdr[k], (len == 0) && (k == total - 1));
        end
        if (len != 0) begin
            open_page  = 1'b1;
            left_count = len;
        end else begin
            page_crc_acc = 32'h0;
        end
    endtask

    task automatic predict_payload(input logic [119:0] d);
        logic last;
        if (!open_page) return;
        left_count = left_count - 12'd1;
        last = (left_count == 12'd0);
        emit_byte(d[118:111], last);
        if (last) begin
            open_page    = 1'b0;
            page_crc_acc = 32'h0;
        end
    endtask

    task automatic check_word;
        t_page_word want;
        if (expected_words.size() == 0) begin
            report_mismatch($sformatf("unexpected transfer, byte %02h", i_m_tdata[7:0]));
            return;
        end
        want = expected_words.pop_front();
        if (i_m_tdata[7:0] !== want.data)
            report_mismatch($sformatf("byte %0d: page_byte %02h, want %02h",
                                      byte_count, i_m_tdata[7:0], want.data));
        if (i_m_tlast !== want.last)
            report_mismatch($sformatf("byte %0d: tlast %b, want %b",
                                      byte_count, i_m_tlast, want.last));
        if (i_m_tdata[39:8] !== want.crc)
            report_mismatch($sformatf("byte %0d: page_crc %08h, want %08h",
                                      byte_count, i_m_tdata[39:8], want.crc));
        byte_count++;
        if (want.last) page_count++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            serial       = SERIAL_RESET;
            page_crc_acc = 32'h0;
            left_count   = 12'h0;
            open_page    = 1'b0;
            expected_words.delete();
        end else begin
            // outputs first: a result never leaves in the cycle its input arrives
            if (i_m_tvalid && i_m_tready) check_word();
            if (i_cfg_we) serial = i_cfg_wdata;
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser == OP_START) predict_start(i_s_tdata);
                else predict_payload(i_s_tdata);
            end
        end
        o_errors  <= err_count;
        o_pending <= expected_words.size();
        o_pages   <= page_count;
        o_bytes   <= byte_count;
    end

endmodule

[tb/sv/ogg_page_framer_crc32_test.sv]
`timescale 1ns / 100ps
// Top-level testbench for the Ogg page framer: stimulus, stalls, serial settings and verdict.
module ogg_page_framer_crc32_test;
    import opf_pkg::*;

    logic         clk       = 1'b0;
    logic         rst_n     = 1'b0;
    logic         cfg_we    = 1'b0;
    logic [31:0]  cfg_wdata = 32'h0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    logic [119:0] s_tdata   = '0;
    logic         s_tuser   = 1'b0;
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    logic [39:0]  m_tdata;
    logic         m_tlast;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int errors;
    int pending;
    int pages;
    int bytes_seen;

    ogg_page_framer_crc32 uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tlast   (m_tlast)
    );

    ogg_page_checker page_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .i_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_m_tdata   (m_tdata),
        .i_m_tlast   (m_tlast),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_pages     (pages),
        .o_bytes     (bytes_seen)
    );

    always #5 clk = ~clk;

    always @(posedge clk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic logic [119:0] start_word(input logic [2:0] flags, input logic [63:0] gran,
                                                input logic [31:0] seq, input logic [11:0] len);
        logic [7:0] noise;
        noise = 8'($urandom);
        return {1'b0, noise, len, seq, gran, flags};
    endfunction

    // header fields carry noise on payload transfers
    function automatic logic [119:0] byte_word(input logic [7:0] b);
        logic [31:0] r0, r1, r2, r3;
        r0 = $urandom;
        r1 = $urandom;
        r2 = $urandom;
        r3 = $urandom;
        return {1'b0, b, r3[11:0], r2, r1, r0, r3[14:12]};
    endfunction

    task automatic send(input logic op, input logic [119:0] d);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= d;
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic send_page(input logic [11:0] len, input int nbytes);
        send(OP_START, start_word(3'($urandom_range(7)), {$urandom, $urandom}, $urandom, len));
        repeat (nbytes) send(OP_BYTE, byte_word(8'($urandom)));
    endtask

    // hold off until every expected byte is out, plus slack for ignored payload
    task automatic drain_all;
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_serial(input logic [31:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic random_phase(input int target);
        int          n;
        int          pick;
        int          cnt;
        logic [11:0] len;
        n = 0;
        while (n < target) begin
            pick = $urandom_range(99);
            if (pick < 60) begin
                len = ($urandom_range(9) == 0) ? 12'($urandom_range(16, 40))
                                               : 12'($urandom_range(15));
                send_page(len, int'(len));
                n += int'(len) + 1;
            end else if (pick < 75) begin
                len = 12'($urandom_range(4095));
                cnt = $urandom_range(4);
                if (cnt > int'(len)) cnt = int'(len);
                send_page(len, cnt);
                n += cnt + 1;
            end else if (pick < 85) begin
                len = 12'(LACE_MAX * $urandom_range(16));
                cnt = $urandom_range(2);
                if (cnt > int'(len)) cnt = int'(len);
                send_page(len, cnt);
                n += cnt + 1;
            end else if (pick < 95) begin
                repeat ($urandom_range(1, 3)) send(OP_BYTE, byte_word(8'($urandom)));
            end else begin
                drain_all();
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed, reset serial
        send(OP_BYTE, byte_word(8'hFF));
        send(OP_START, start_word(3'd0, 64'h0, 32'h0, 12'd0));
        send(OP_START, start_word(3'd7, '1, '1, 12'd1));
        send(OP_BYTE, byte_word(8'h00));
        send(OP_START, start_word(3'd2, 64'h0123_4567_89AB_CDEF, 32'h89AB_CDEF, 12'd4095));
        send(OP_BYTE, byte_word(8'hA5));
        send(OP_START, start_word(3'd4, 64'hFEDC_BA98_7654_3210, 32'h7654_3210, 12'd255));
        send(OP_BYTE, byte_word(8'hFF));
        send(OP_BYTE, byte_word(8'h00));
        send(OP_START, start_word(3'd1, 64'h8000_0000_0000_0001, 32'h8000_0001, 12'd3));
        send(OP_BYTE, byte_word(8'h80));
        send(OP_BYTE, byte_word(8'h7F));
        send(OP_BYTE, byte_word(8'h01));
        send(OP_BYTE, byte_word(8'h55));
        drain_all();
        send(OP_START, start_word(3'd3, 64'h5555_5555_5555_5555, 32'hAAAA_AAAA, 12'd254));
        send(OP_START, start_word(3'd6, 64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_5555, 12'd510));
        send(OP_START, start_word(3'd5, 64'h0, 32'h1, 12'd2));
        send(OP_BYTE, byte_word(8'hC3));
        send(OP_BYTE, byte_word(8'h3C));
        drain_all();

        write_serial(32'hFFFF_FFFF);
        send_idle_pct = 34;
        recv_idle_pct = 59;
        random_phase(65);
        drain_all();

        write_serial(32'h0);
        send_idle_pct = 59;
        recv_idle_pct = 34;
        random_phase(65);
        drain_all();

        write_serial($urandom);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(65);
        drain_all();
        repeat (10) @(posedge clk);

        $display("Checked %0d page bytes over %0d completed pages.", bytes_seen, pages);
        $display("Serial reset/all-ones/zero/random; stalls on both sides, then none.");
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Timeout: page bytes still outstanding");
        $display("*** FAILED ***");
        $finish;
    end

endmodule
